@@ design/ise_pkg.sv @@
// ----------------------------------------------------------------------------
// ise_pkg
// Shared constants and types for the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] value_t;

  // What one cell exposes to its neighbours.
  typedef struct packed {
    value_t val;
    logic   valid;
    logic   gt;
  } cell_link_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

@@ design/ise_in_if.sv @@
// ----------------------------------------------------------------------------
// ise_in_if
// Input channel: one element of the data set per transfer.
// ----------------------------------------------------------------------------
interface ise_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [ise_pkg::VAL_W-1:0] value;
  logic                      end_of_set;

  modport source (output valid, output value, output end_of_set, input ready);
  modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

@@ design/ise_out_if.sv @@
// ----------------------------------------------------------------------------
// ise_out_if
// Output channel: one element of the sorted run per transfer.
// ----------------------------------------------------------------------------
interface ise_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [ise_pkg::VAL_W-1:0] sorted_value;
  logic                      last_of_run;
  logic                      overflow;

  modport source (output valid, output sorted_value, output last_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_of_run,
                  input overflow, output ready);
endinterface

@@ design/insertion_sort_engine.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Sorts one data set at a time in a chain of insertion cells, then streams
// the set out in ascending order.
//
//   channel  | dir | payload                                  | ends run
//   ---------+-----+------------------------------------------+-------------
//   items    | in  | value[31:0] signed, end_of_set           | end_of_set
//   results  | out | sorted_value[31:0], last_of_run, overflow| last_of_run
//
// Loading takes one element per cycle: every cell compares against the
// incoming value in parallel and the larger entries move one slot right.
// After the element flagged end_of_set, the chain shifts towards cell 0 and
// presents one result per cycle while the results channel is ready. No
// input is taken while draining. Reset clears the valid bits directly;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module insertion_sort_engine (
  input  logic      clk,
  input  logic      rst,
  ise_in_if.sink    items,
  ise_out_if.source results
);
  import ise_pkg::*;

  state_t     state, state_next;
  logic       dropped, dropped_next;
  cell_ctrl_t ctrl;
  cell_link_t link [CAPACITY];
  logic       in_xfer, out_xfer, full;

  assign full     = link[CAPACITY-1].valid;
  assign in_xfer  = items.valid && items.ready;
  assign out_xfer = results.valid && results.ready;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_t left, right;
      if (i == 0) begin : g_first
        assign left = '0;
      end else begin : g_left
        assign left = link[i-1];
      end
      if (i == CAPACITY-1) begin : g_end
        assign right = '0;
      end else begin : g_right
        assign right = link[i+1];
      end
      ise_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .ins_value (items.value),
        .left      (left),
        .right     (right),
        .link      (link[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    ctrl         = '0;
    items.ready  = 1'b0;
    results.valid = 1'b0;
    case (state)
      ST_LOAD: begin
        items.ready = 1'b1;
        if (in_xfer) begin
          // Drop the element when the chain is full, but remember that one was dropped.
          ctrl.insert = !full;
          if (full) begin
            dropped_next = 1'b1;
          end
          if (items.end_of_set) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        results.valid = link[0].valid;
        if (out_xfer) begin
          ctrl.shift = 1'b1;
          if (!link[1].valid) begin
            state_next   = ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign results.sorted_value = link[0].val;
  assign results.last_of_run  = !link[1].valid;
  assign results.overflow     = dropped;

endmodule

@@ design/ise_cell.sv @@
// ----------------------------------------------------------------------------
// ise_cell
// One slot of the sorted chain. Compares its entry with the broadcast value;
// on insert takes the left entry or that value, on drain the right one.
// ----------------------------------------------------------------------------
module ise_cell (
  input  logic                clk,
  input  logic                rst,
  input  ise_pkg::cell_ctrl_t ctrl,
  input  ise_pkg::value_t     ins_value,
  input  ise_pkg::cell_link_t left,
  input  ise_pkg::cell_link_t right,
  output ise_pkg::cell_link_t link
);
  import ise_pkg::*;

  value_t val;
  logic   valid;
  logic   gt;

  // An empty slot counts as greater than anything; equal values stay put.
  assign gt = !valid || (val > ins_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      val <= left.gt ? left.val : ins_value;
    end else if (ctrl.shift) begin
      val <= right.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert && gt) begin
      valid <= left.gt ? left.valid : 1'b1;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end
  end

  assign link = '{val: val, valid: valid, gt: gt};

endmodule

@@ design/ise_checker.sv @@
// ----------------------------------------------------------------------------
// ise_checker
// Port-level checks on the insertion sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module ise_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_end_of_set,
  input logic out_valid,
  input logic out_ready,
  input logic signed [ise_pkg::VAL_W-1:0] out_sorted_value,
  input logic out_last_of_run,
  input logic out_overflow
);
  import ise_pkg::*;

  // Loading and draining never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while results pending");

  // After the end of a set, a run starts and input is held off.
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_end_of_set) |=> (out_valid && !in_ready))
    else $error("run did not start after end of set");

  // The run closes after its last result.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last_of_run) |=> (!out_valid && in_ready))
    else $error("results continued after last of run");

  // Within a run, results keep coming and overflow does not change.
  a_run_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last_of_run) |=>
      (out_valid && out_overflow == $past(out_overflow)))
    else $error("run broken or overflow changed mid-run");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sorted_value)))
    else $error("stalled result changed");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (items.valid),
  .in_ready         (items.ready),
  .in_end_of_set    (items.end_of_set),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .out_sorted_value (results.sorted_value),
  .out_last_of_run  (results.last_of_run),
  .out_overflow     (results.overflow)
);
